/* rtl/otf_pkg.sv */
package otf_pkg;

   localparam int unsigned HIST_DEPTH = 256;
   localparam logic [7:0] THR_INIT = 8'd128;

   localparam logic [7:0] REG_FIXED_MODE = 8'd0;
   localparam logic [7:0] REG_FIXED_THRESHOLD = 8'd1;

   typedef struct packed {
      logic pix_accept;
      logic t_clr;
      logic t_inc;
      logic rd_hist;
      logic srch_init;
      logic srch_acc;
      logic mul_x;
      logic mul_y;
      logic mul_den;
      logic sq_step;
      logic div_init;
      logic div_step;
      logic cmp;
      logic thr_load;
      logic white_clr;
      logic sweep_wr;
      logic clr_wr;
      logic frame_clr;
   } cmd_type;

   typedef struct packed {
      logic cw_zero;
      logic cw_full;
      logic t_last;
      logic sq_last;
      logic div_last;
   } sts_type;

endpackage

/* rtl/otf_datapath.sv */
module otf_datapath #(
   parameter int unsigned MAX_PIXELS = 32768
) (
   input  logic             clock,
   input  logic             reset,
   input  otf_pkg::cmd_type cmd,
   output otf_pkg::sts_type sts,
   input  logic [7:0]       pixel,
   input  logic             fixed_mode,
   input  logic [7:0]       fixed_threshold,
   output logic [7:0]       threshold,
   output logic [15:0]      white_count
);

   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int SW = CW + 8;
   localparam int DW = CW + SW;
   localparam int PW = 2 * DW;
   localparam int NW = 2 * CW;
   localparam int IW = $clog2(PW);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PIXELS);

   logic [CW-1:0] hist_mem [otf_pkg::HIST_DEPTH];
   logic [CW-1:0] rdata_ff;
   logic          rd_en, wr_en, pix_rd;
   logic [7:0]    rd_addr, wr_addr;
   logic [CW-1:0] wr_data, bump;

   logic          pend_ff, last_wr_v_ff;
   logic [7:0]    pend_addr_ff, last_wr_addr_ff;
   logic [CW-1:0] last_wr_data_ff;

   logic [CW-1:0] count_ff, cw_ff, white_ff;
   logic [SW-1:0] sum_ff, cs_ff;
   logic [7:0]    t_ff, best_thr_ff, thr_ff;
   logic [DW-1:0] x_ff, y_ff, dm_ff, dsh_ff;
   logic [NW-1:0] den_ff, r_ff;
   logic [PW-1:0] p_ff, q_ff, best_ff;
   logic [IW-1:0] iter_ff;
   logic [NW:0]   rs;

   assign pix_rd  = cmd.pix_accept && (count_ff < MAX_COUNT);
   assign rd_en   = cmd.rd_hist || pix_rd;
   assign rd_addr = cmd.pix_accept ? pixel : t_ff;
   assign bump    = ((last_wr_v_ff && (last_wr_addr_ff == pend_addr_ff)) ? last_wr_data_ff
                                                                         : rdata_ff) + 1'b1;
   assign wr_en   = pend_ff || cmd.sweep_wr || cmd.clr_wr;
   assign wr_addr = pend_ff ? pend_addr_ff : t_ff;
   assign wr_data = pend_ff ? bump : '0;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= hist_mem[rd_addr];
      end
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         last_wr_v_ff <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         t_ff         <= '0;
      end else begin
         pend_ff      <= pix_rd;
         last_wr_v_ff <= pend_ff;
         if (cmd.frame_clr) begin
            count_ff <= '0;
            sum_ff   <= '0;
         end else if (pix_rd) begin
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_ff + SW'(pixel);
         end
         if (cmd.t_clr || cmd.srch_init) begin
            t_ff <= '0;
         end else if (cmd.t_inc) begin
            t_ff <= t_ff + 1'b1;
         end
      end
   end

   assign rs = {r_ff, p_ff[PW-1]};

   always_ff @(posedge clock) begin
      pend_addr_ff    <= pixel;
      last_wr_addr_ff <= pend_addr_ff;
      last_wr_data_ff <= bump;
      if (cmd.srch_init) begin
         cw_ff       <= '0;
         cs_ff       <= '0;
         best_ff     <= '0;
         best_thr_ff <= otf_pkg::THR_INIT;
      end
      if (cmd.srch_acc) begin
         cw_ff <= cw_ff + rdata_ff;
         cs_ff <= cs_ff + SW'(t_ff) * SW'(rdata_ff);
      end
      if (cmd.mul_x) begin
         x_ff <= DW'(count_ff) * DW'(cs_ff);
      end
      if (cmd.mul_y) begin
         y_ff <= DW'(cw_ff) * DW'(sum_ff);
      end
      if (cmd.mul_den) begin
         den_ff  <= NW'(cw_ff) * NW'(count_ff - cw_ff);
         dm_ff   <= (x_ff >= y_ff) ? (x_ff - y_ff) : (y_ff - x_ff);
         dsh_ff  <= (x_ff >= y_ff) ? (x_ff - y_ff) : (y_ff - x_ff);
         p_ff    <= '0;
         iter_ff <= '0;
      end
      if (cmd.sq_step) begin
         p_ff    <= {p_ff[PW-2:0], 1'b0} + (dsh_ff[DW-1] ? PW'(dm_ff) : '0);
         dsh_ff  <= {dsh_ff[DW-2:0], 1'b0};
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.div_init) begin
         r_ff    <= '0;
         q_ff    <= '0;
         iter_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rs >= {1'b0, den_ff}) begin
            r_ff <= NW'(rs - {1'b0, den_ff});
            q_ff <= {q_ff[PW-2:0], 1'b1};
         end else begin
            r_ff <= NW'(rs);
            q_ff <= {q_ff[PW-2:0], 1'b0};
         end
         p_ff    <= {p_ff[PW-2:0], 1'b0};
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.cmp && (q_ff > best_ff)) begin
         best_ff     <= q_ff;
         best_thr_ff <= t_ff;
      end
      if (cmd.thr_load) begin
         thr_ff <= fixed_mode ? fixed_threshold : best_thr_ff;
      end
      if (cmd.white_clr) begin
         white_ff <= '0;
      end else if (cmd.sweep_wr && (t_ff > thr_ff)) begin
         white_ff <= white_ff + rdata_ff;
      end
   end

   assign sts.cw_zero  = (cw_ff == '0);
   assign sts.cw_full  = (cw_ff >= count_ff);
   assign sts.t_last   = (t_ff == 8'hFF);
   assign sts.sq_last  = (iter_ff == IW'(DW - 1));
   assign sts.div_last = (iter_ff == IW'(PW - 1));

   assign threshold   = thr_ff;
   assign white_count = 16'(white_ff);

endmodule

/* rtl/otf_ctrl.sv */
module otf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             fixed_mode,
   input  otf_pkg::sts_type sts,
   output otf_pkg::cmd_type cmd
);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_ACC    = 4'd1;
   localparam logic [3:0] S_DRAIN  = 4'd2;
   localparam logic [3:0] S_SR_RD  = 4'd3;
   localparam logic [3:0] S_SR_ADD = 4'd4;
   localparam logic [3:0] S_SR_CHK = 4'd5;
   localparam logic [3:0] S_MX     = 4'd6;
   localparam logic [3:0] S_MY     = 4'd7;
   localparam logic [3:0] S_MDEN   = 4'd8;
   localparam logic [3:0] S_SQ     = 4'd9;
   localparam logic [3:0] S_DIV    = 4'd10;
   localparam logic [3:0] S_CMP    = 4'd11;
   localparam logic [3:0] S_THR    = 4'd12;
   localparam logic [3:0] S_SW_RD  = 4'd13;
   localparam logic [3:0] S_SW_WR  = 4'd14;
   localparam logic [3:0] S_DINIT  = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_ACC);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.pix_accept = req_tvalid && req_tready;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            cmd.t_inc  = 1'b1;
            if (sts.t_last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (cmd.pix_accept && req_tlast) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rsp_valid_ff) begin
               if (fixed_mode) begin
                  state_in = S_THR;
               end else begin
                  cmd.srch_init = 1'b1;
                  state_in      = S_SR_RD;
               end
            end
         end
         S_SR_RD: begin
            cmd.rd_hist = 1'b1;
            state_in    = S_SR_ADD;
         end
         S_SR_ADD: begin
            cmd.srch_acc = 1'b1;
            state_in     = S_SR_CHK;
         end
         S_SR_CHK: begin
            if (sts.cw_zero) begin
               if (sts.t_last) begin
                  state_in = S_THR;
               end else begin
                  cmd.t_inc = 1'b1;
                  state_in  = S_SR_RD;
               end
            end else if (sts.cw_full) begin
               state_in = S_THR;
            end else begin
               state_in = S_MX;
            end
         end
         S_MX: begin
            cmd.mul_x = 1'b1;
            state_in  = S_MY;
         end
         S_MY: begin
            cmd.mul_y = 1'b1;
            state_in  = S_MDEN;
         end
         S_MDEN: begin
            cmd.mul_den = 1'b1;
            state_in    = S_SQ;
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            if (sts.sq_last) begin
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            if (sts.t_last) begin
               state_in = S_THR;
            end else begin
               cmd.t_inc = 1'b1;
               state_in  = S_SR_RD;
            end
         end
         S_THR: begin
            cmd.thr_load  = 1'b1;
            cmd.t_clr     = 1'b1;
            cmd.white_clr = 1'b1;
            state_in      = S_SW_RD;
         end
         S_SW_RD: begin
            cmd.rd_hist = 1'b1;
            state_in    = S_SW_WR;
         end
         S_SW_WR: begin
            cmd.sweep_wr = 1'b1;
            cmd.t_inc    = 1'b1;
            if (sts.t_last) begin
               cmd.frame_clr = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_ACC;
            end else begin
               state_in = S_SW_RD;
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_last_stops_intake: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("intake open after frame end");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.thr_load |-> !rsp_valid_ff)
      else $error("threshold reloaded while result pending");

   a_result_from_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_SW_WR))
      else $error("result raised outside sweep end");

endmodule

/* rtl/otsu_frame_threshold_core.sv */
// channel  direction  handshake               payload
// req      in         req_tvalid/req_tready   tdata: pixel[7:0]; tlast: last_pixel
// rsp      out        rsp_tvalid/rsp_tready   tdata: threshold[7:0], white_count[23:8]
// csr      in         csr_valid/csr_ready     csr_index[7:0], csr_wdata[7:0]
//
// While ready, pixels go in one per cycle; each bin write lands in the next cycle.
// After the last pixel, unless in fixed mode, the search reads, adds and checks each
// bin in turn: empty leading bins are skipped, a split with pixels on both sides is
// scored by the bit-serial square and divider, and it ends when none lie above.
// A sweep then counts white pixels and clears the histogram memory.
// After reset a clearing pass over all 256 bins runs before the first pixel is taken.
// A pending result holds until taken; the next frame is collected meanwhile.
module otsu_frame_threshold_core #(
   parameter int unsigned MAX_PIXELS = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel
   input  logic        req_tlast,   // last_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // threshold, white_count
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic             fixed_mode_ff;
   logic [7:0]       fixed_threshold_ff;
   otf_pkg::cmd_type cmd;
   otf_pkg::sts_type sts;
   logic [7:0]       threshold;
   logic [15:0]      white_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_mode_ff      <= 1'b0;
         fixed_threshold_ff <= otf_pkg::THR_INIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            otf_pkg::REG_FIXED_MODE:      fixed_mode_ff      <= csr_wdata[0];
            otf_pkg::REG_FIXED_THRESHOLD: fixed_threshold_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   otf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .fixed_mode (fixed_mode_ff),
      .sts        (sts),
      .cmd        (cmd)
   );

   otf_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .pixel           (req_tdata),
      .fixed_mode      (fixed_mode_ff),
      .fixed_threshold (fixed_threshold_ff),
      .threshold       (threshold),
      .white_count     (white_count)
   );

   assign rsp_tdata = {white_count, threshold};

endmodule
